/* hdl/sils_pkg.sv */
package sils_pkg;

    localparam int MAX_DIM_DEF = 16;
    localparam int DIM_HARD    = 16;
    localparam int DIM_W       = 5;
    localparam int CFG_IDX_W   = 2;

    localparam logic [15:0] STEP_RST = 16'd655;
    localparam logic [31:0] TOL_RST  = 32'd429497;
    localparam logic [15:0] CAP_RST  = 16'hFFFF;
    localparam logic [4:0]  SIZE_RST = 5'd16;

    // request codes
    localparam logic [1:0] REQ_MAT   = 2'd0;
    localparam logic [1:0] REQ_RHS   = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 2'd3;

    typedef struct packed {
        logic clear;
        logic shift;
        logic push;
        logic commit;
    } t_cell_ctl;

    function automatic logic signed [63:0] sat_add_s64(
        input logic signed [63:0] a, input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63])
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    function automatic logic [63:0] sat_add_u64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = 65'(a) + 65'(b);
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

/* hdl/sils_in_if.sv */
interface sils_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [31:0] value;

    modport source (output valid, req_type, row, col, value, input ready);
    modport sink   (input valid, req_type, row, col, value, output ready);
endinterface

/* hdl/sils_out_if.sv */
interface sils_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         index;
    logic signed [31:0] solution;
    logic               last;
    logic               converged;
    logic [15:0]        iterations;

    modport source (output valid, index, solution, last, converged, iterations, input ready);
    modport sink   (input valid, index, solution, last, converged, iterations, output ready);
endinterface

/* hdl/sils_cell.sv */
module sils_cell import sils_pkg::*; (
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic signed [31:0] i_x,
    input  logic signed [31:0] i_xn,
    output logic signed [31:0] o_x,
    output logic signed [31:0] o_xn
);

    logic signed [31:0] r_x;
    logic signed [31:0] r_xn;

    // current estimate rotates around the ring, next estimate fills from the tail
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_x <= '0;
        end else if (i_ctl.commit) begin
            r_x <= r_xn;
        end else if (i_ctl.shift) begin
            r_x <= i_x;
        end
        if (i_ctl.push) begin
            r_xn <= i_xn;
        end
    end

    assign o_x  = r_x;
    assign o_xn = r_xn;

endmodule

/* hdl/simple_iteration_linear_solver.sv */
// channel   dir  words                                   handshake
// i_req     in   req_type, row, col, value               valid/ready
// o_res     out  index, solution, last, converged, iters valid/ready
// cfg       in   i_cfg_index, i_cfg_data                 i_cfg_valid/o_cfg_ready
//
// load words are taken back to back while idle; ready drops while a solve runs
// a solve of dimension n: setup first (norm of b, threshold product in four 32x32
// partial products), then iterations, each paced row by row by the single matrix
// memory read port feeding one multiply-accumulate
// results leave one word per cycle from the output register; a stalled sink holds it
// synchronous active-low reset resets control and config registers, not the stores or the datapath
module simple_iteration_linear_solver import sils_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sils_in_if.sink              i_req,
    sils_out_if.source           o_res,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int RW      = $clog2(MAX_DIM);
    localparam int AW      = $clog2(MAX_DIM * MAX_DIM);
    localparam int DIM_LIM = (MAX_DIM < DIM_HARD) ? MAX_DIM : DIM_HARD;

    typedef enum logic [3:0] {
        S_IDLE, S_NORM_M, S_NORM_A, S_E2, S_THR, S_ROW_MAC, S_ROW_WAIT,
        S_ROW_B, S_ROW_R, S_ROW_M, S_ROW_X, S_COMMIT, S_OUT
    } t_state;

    // configuration registers
    logic [15:0] r_step;
    logic [31:0] r_tol;
    logic [15:0] r_cap_cfg;
    logic [4:0]  r_size;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= STEP_RST;
            r_tol     <= TOL_RST;
            r_cap_cfg <= CAP_RST;
            r_size    <= SIZE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_STEP: r_step    <= i_cfg_data[15:0];
                CFG_TOL:  r_tol     <= i_cfg_data;
                CFG_CAP:  r_cap_cfg <= i_cfg_data[15:0];
                CFG_SIZE: r_size    <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    t_state              r_state;
    logic [DIM_W-1:0]    r_dim;
    logic [15:0]         r_cap;
    logic [15:0]         r_cnt;
    logic [DIM_W-1:0]    r_i;
    logic [DIM_W-1:0]    r_j;
    logic                r_v1;
    logic                r_v2;
    logic signed [31:0]  r_aq;
    logic signed [31:0]  r_xj;
    logic signed [31:0]  r_xi;
    logic signed [63:0]  r_prod;
    logic signed [63:0]  r_acc;
    logic signed [63:0]  r_bb;
    logic [63:0]         r_nb2;
    logic [63:0]         r_e2;
    logic [63:0]         r_pp;
    logic [1:0]          r_psh;
    logic [2:0]          r_k;
    logic [127:0]        r_thr;
    logic signed [31:0]  r_r;
    logic signed [49:0]  r_pt;
    logic signed [63:0]  r_rr;
    logic [63:0]         r_res2;
    logic                r_conv;

    // output register
    logic                r_ov;
    logic [3:0]          r_oidx;
    logic signed [31:0]  r_osol;
    logic                r_olast;
    logic                r_oconv;
    logic [15:0]         r_oiter;

    // stores
    logic signed [31:0] r_mat [MAX_DIM*MAX_DIM];
    logic signed [31:0] r_rhs [MAX_DIM];

    logic accept;
    logic is_start;
    logic out_load;
    logic dim_last_i;
    logic signed [31:0] w_b;
    logic [AW-1:0] w_wr_addr;
    logic [AW-1:0] w_rd_addr;
    logic [DIM_W-1:0] w_dim_new;
    logic signed [63:0] w_bneg;
    logic signed [49:0] w_d;
    logic signed [50:0] w_xdiff;
    logic signed [31:0] w_xnew;
    logic [63:0] w_thr_hi;
    logic [63:0] w_thr_lo;
    logic w_conv;
    logic [15:0] w_cnt_inc;
    logic [31:0] w_pa;
    logic [31:0] w_pb;
    logic [127:0] w_pp_sh;
    t_cell_ctl cell_ctl;

    logic signed [31:0] w_x  [MAX_DIM];
    logic signed [31:0] w_xn [MAX_DIM];

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign is_start    = accept && (i_req.req_type == REQ_START);
    assign out_load    = (r_state == S_OUT) && (!r_ov || o_res.ready);
    assign dim_last_i  = (r_i == r_dim - 5'd1);

    assign w_wr_addr = AW'(32'(i_req.row) * MAX_DIM + 32'(i_req.col));
    assign w_rd_addr = AW'(32'(r_i) * MAX_DIM + 32'(r_j));
    assign w_b       = r_rhs[RW'(r_i)];

    // zero dimension runs as one, large dimensions clip to the smaller of the store size and DIM_HARD
    always_comb begin
        if (r_size == '0)
            w_dim_new = 5'd1;
        else if (32'(r_size) > DIM_LIM)
            w_dim_new = DIM_W'(DIM_LIM);
        else
            w_dim_new = r_size;
    end

    // store writes and registered matrix read
    always_ff @(posedge i_clk) begin
        if (accept && i_req.req_type == REQ_MAT && 32'(i_req.row) < MAX_DIM
                && 32'(i_req.col) < MAX_DIM) begin
            r_mat[w_wr_addr] <= i_req.value;
        end
        if (accept && i_req.req_type == REQ_RHS && 32'(i_req.row) < MAX_DIM) begin
            r_rhs[RW'(i_req.row)] <= i_req.value;
        end
        r_aq <= r_mat[w_rd_addr];
    end

    // row finishing arithmetic
    assign w_bneg  = -(64'(w_b) <<< 16);
    assign w_d     = (r_pt + 50'sd32768) >>> 16;
    assign w_xdiff = 51'(r_xi) - 51'(w_d);
    assign w_xnew  = sat32(64'(w_xdiff));

    // threshold eps^2 * |b|^2 as a 128-bit product, compared against res2 * 2^64
    assign w_thr_hi  = r_thr[127:64];
    assign w_thr_lo  = r_thr[63:0];
    assign w_conv    = (r_res2 < w_thr_hi) || (r_res2 == w_thr_hi && w_thr_lo != '0);
    assign w_cnt_inc = r_cnt + 16'd1;

    // partial products lo*lo, lo*hi, hi*lo, hi*hi
    assign w_pa    = r_k[1] ? r_e2[63:32] : r_e2[31:0];
    assign w_pb    = r_k[0] ? r_nb2[63:32] : r_nb2[31:0];
    assign w_pp_sh = {64'd0, r_pp} << (7'(r_psh) * 7'd32);

    // cell chain control
    assign cell_ctl.clear  = is_start;
    assign cell_ctl.shift  = (r_state == S_ROW_MAC) || out_load;
    assign cell_ctl.push   = (r_state == S_ROW_X);
    assign cell_ctl.commit = (r_state == S_COMMIT);

    for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
        logic signed [31:0] x_in;
        logic signed [31:0] xn_in;
        if (k == MAX_DIM - 1) begin : g_tail
            assign x_in  = w_x[0];
            assign xn_in = w_xnew;
        end else begin : g_body
            // the cell at position n-1 closes the ring
            assign x_in  = ((32'(r_dim) - 32'd1) == k) ? w_x[0] : w_x[k+1];
            assign xn_in = ((32'(r_dim) - 32'd1) == k) ? w_xnew : w_xn[k+1];
        end
        sils_cell u_cell (
            .i_clk (i_clk),
            .i_ctl (cell_ctl),
            .i_x   (x_in),
            .i_xn  (xn_in),
            .o_x   (w_x[k]),
            .o_xn  (w_xn[k])
        );
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_ov    <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_cnt   <= '0;
            r_dim   <= SIZE_RST;
            r_cap   <= CAP_RST;
            r_conv  <= 1'b0;
        end else begin
            // mac pipe: read issue, product, accumulate
            r_v1 <= (r_state == S_ROW_MAC);
            r_v2 <= r_v1;
            if (r_v1) r_prod <= r_aq * r_xj;
            if (r_v2) r_acc <= sat_add_s64(r_acc, r_prod);

            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (is_start) begin
                        r_dim   <= w_dim_new;
                        r_cap   <= (r_cap_cfg == '0) ? 16'd1 : r_cap_cfg;
                        r_cnt   <= '0;
                        r_nb2   <= '0;
                        r_i     <= '0;
                        r_state <= S_NORM_M;
                    end
                end
                S_NORM_M: begin
                    r_bb    <= w_b * w_b;
                    r_state <= S_NORM_A;
                end
                S_NORM_A: begin
                    r_nb2 <= sat_add_u64(r_nb2, r_bb);
                    if (dim_last_i) begin
                        r_state <= S_E2;
                    end else begin
                        r_i     <= r_i + 5'd1;
                        r_state <= S_NORM_M;
                    end
                end
                S_E2: begin
                    r_e2    <= 64'(r_tol) * 64'(r_tol);
                    r_k     <= '0;
                    r_thr   <= '0;
                    r_state <= S_THR;
                end
                S_THR: begin
                    // four partial products, each added in the cycle after it forms
                    if (r_k <= 3'd3) begin
                        r_pp  <= 64'(w_pa) * 64'(w_pb);
                        r_psh <= 2'(r_k[0]) + 2'(r_k[1]);
                    end
                    if (r_k != '0) r_thr <= r_thr + w_pp_sh;
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd4) begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_acc   <= '0;
                        r_res2  <= '0;
                        r_state <= S_ROW_MAC;
                    end
                end
                S_ROW_MAC: begin
                    r_xj <= w_x[0];
                    if (r_j == r_i) r_xi <= w_x[0];
                    r_j <= r_j + 5'd1;
                    if (r_j == r_dim - 5'd1) r_state <= S_ROW_WAIT;
                end
                S_ROW_WAIT: begin
                    if (!r_v1 && !r_v2) r_state <= S_ROW_B;
                end
                S_ROW_B: begin
                    r_acc   <= sat_add_s64(r_acc, w_bneg);
                    r_state <= S_ROW_R;
                end
                S_ROW_R: begin
                    r_r     <= sat32(r_acc >>> 16);
                    r_state <= S_ROW_M;
                end
                S_ROW_M: begin
                    r_pt    <= $signed({1'b0, r_step}) * r_r;
                    r_rr    <= r_r * r_r;
                    r_state <= S_ROW_X;
                end
                S_ROW_X: begin
                    r_res2 <= sat_add_u64(r_res2, r_rr);
                    if (dim_last_i) begin
                        r_state <= S_COMMIT;
                    end else begin
                        r_i     <= r_i + 5'd1;
                        r_j     <= '0;
                        r_acc   <= '0;
                        r_state <= S_ROW_MAC;
                    end
                end
                S_COMMIT: begin
                    r_cnt <= w_cnt_inc;
                    r_i   <= '0;
                    if (w_conv) begin
                        r_conv  <= 1'b1;
                        r_state <= S_OUT;
                    end else if (w_cnt_inc >= r_cap) begin
                        r_conv  <= 1'b0;
                        r_state <= S_OUT;
                    end else begin
                        r_j     <= '0;
                        r_acc   <= '0;
                        r_res2  <= '0;
                        r_state <= S_ROW_MAC;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_oidx  <= r_i[3:0];
                        r_osol  <= w_x[0];
                        r_olast <= dim_last_i;
                        r_oconv <= r_conv;
                        r_oiter <= r_cnt;
                        r_i     <= r_i + 5'd1;
                        if (dim_last_i) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid      = r_ov;
    assign o_res.index      = r_oidx;
    assign o_res.solution   = r_osol;
    assign o_res.last       = r_olast;
    assign o_res.converged  = r_oconv;
    assign o_res.iterations = r_oiter;

    // dimension in force stays inside the supported range
    a_dim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_dim != '0 && 32'(r_dim) <= DIM_LIM))
        else $error("solve dimension out of range");

    // accumulate stage only follows a product stage
    a_pipe_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> $past(r_v1))
        else $error("mac pipe out of order");

    // every row has been finished when an iteration commits
    a_commit_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT) |-> (r_i == r_dim - 5'd1))
        else $error("commit before last row");

    // the iteration count never passes the cap
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_cnt <= r_cap && r_cnt != '0))
        else $error("iteration count beyond cap");

    // the ring is idle while row results drain
    a_no_shift_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROW_WAIT) |=> !(r_state == S_ROW_MAC))
        else $error("row restarted before drain");

endmodule
